// ----- rtl/mpsa_pkg.sv -----
// ----------------------------------------------------------------------------
// mpsa_pkg: shared types and constants of the multi-pattern shift-and matcher
// Field widths, stream packing widths, action codes and front-end states.
// ----------------------------------------------------------------------------
package mpsa_pkg;

  // Default sizing of the pattern store
  localparam int NUM_PATTERNS_DEF = 8;
  localparam int MAX_LEN_DEF      = 8;
  localparam int CHARSET_DEF      = 256;

  // Fixed widths
  localparam int VEC_W      = 64;  // state vector width
  localparam int BITPOS_W   = 10;  // slot * stride + index, 8 slots of up to 64
  localparam int LEN_W      = 4;   // match_length
  localparam int TPOS_W     = 32;  // text position / match_start
  localparam int BYTE_W     = 8;
  localparam int SLOT_IN_W  = 3;
  localparam int IDX_IN_W   = 3;
  localparam int ACT_W      = 2;
  localparam int RESULT_CAP = 8;   // results per text byte
  localparam int CNT_W      = $clog2(RESULT_CAP);

  // Stream packing
  localparam int IN_TDATA_W  = 16; // data_byte, pattern_slot, char_index, pad
  localparam int OUT_TDATA_W = 40; // match_length, match_start, pad

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR    = 2'd0,
    ACT_LOAD     = 2'd1,
    ACT_NEW_TEXT = 2'd2,
    ACT_TEXT     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_LOAD,
    FE_TEXT
  } fe_state_e;

endpackage

// ----- rtl/mpsa_queue.sv -----
// ----------------------------------------------------------------------------
// mpsa_queue: short FIFO between front and back end
// Holds per-byte match records so either side can stall on its own.
// ----------------------------------------------------------------------------
module mpsa_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mpsa_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = data_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");

  a_cnt_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o) else $error("queue lost a pushed record");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH)) else $error("queue count overflow");

endmodule

// ----- rtl/mpsa_front.sv -----
// ----------------------------------------------------------------------------
// mpsa_front: input decode, pattern store and shift-and vector update
// Owns the character mask memory, start/accept vectors, slot lengths,
// active vector and text position; pushes one record per matching text byte.
// ----------------------------------------------------------------------------
module mpsa_front #(
  parameter int NUM_PATTERNS = mpsa_pkg::NUM_PATTERNS_DEF,
  parameter int MAX_LEN      = mpsa_pkg::MAX_LEN_DEF,
  parameter int CHARSET      = mpsa_pkg::CHARSET_DEF,
  parameter int ENTRY_W      = NUM_PATTERNS * (mpsa_pkg::LEN_W + 1) + mpsa_pkg::TPOS_W
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [mpsa_pkg::IN_TDATA_W-1:0] s_tdata_i,
  input  logic [mpsa_pkg::ACT_W-1:0]      s_tuser_i,
  input  logic                            s_tlast_i,
  output logic                            q_push_o,
  output logic [ENTRY_W-1:0]              q_data_o,
  input  logic                            q_full_i
);

  localparam int VEC_W    = mpsa_pkg::VEC_W;
  localparam int BITPOS_W = mpsa_pkg::BITPOS_W;
  localparam int LEN_W    = mpsa_pkg::LEN_W;
  localparam int TPOS_W   = mpsa_pkg::TPOS_W;
  localparam int BYTE_W   = mpsa_pkg::BYTE_W;
  localparam int ADDR_W   = $clog2(CHARSET);
  localparam int LENS_W   = NUM_PATTERNS * LEN_W;
  localparam logic [VEC_W-1:0] FIELD_ONES = {VEC_W{1'b1}} >> (VEC_W - MAX_LEN);

  // Input fields
  mpsa_pkg::action_e               act;
  logic [BYTE_W-1:0]               in_byte;
  logic [mpsa_pkg::SLOT_IN_W-1:0]  in_slot;
  logic [mpsa_pkg::IDX_IN_W-1:0]   in_idx;

  assign act     = mpsa_pkg::action_e'(s_tuser_i);
  assign in_byte = s_tdata_i[BYTE_W-1:0];
  assign in_slot = s_tdata_i[BYTE_W +: mpsa_pkg::SLOT_IN_W];
  assign in_idx  = s_tdata_i[BYTE_W + mpsa_pkg::SLOT_IN_W +: mpsa_pkg::IDX_IN_W];

  mpsa_pkg::fe_state_e state_q, state_d;

  logic [CHARSET-1:0] valid_q, valid_d;
  logic [VEC_W-1:0]   start_q, start_d;
  logic [VEC_W-1:0]   accept_q, accept_d;
  logic [LENS_W-1:0]  lens_q, lens_d;
  logic [VEC_W-1:0]   active_q, active_d;
  logic [TPOS_W-1:0]  pos_q, pos_d;
  logic [ADDR_W-1:0]  op_addr_q, op_addr_d;
  logic [VEC_W-1:0]   op_bit_q, op_bit_d;
  logic               op_inrange_q, op_inrange_d;

  // Character mask memory
  logic [VEC_W-1:0] mem [CHARSET];
  logic [VEC_W-1:0] mem_rdata_q;
  logic             mem_re, mem_we;
  logic [VEC_W-1:0] mem_wdata;

  // Load decode
  logic [BITPOS_W-1:0] ld_base, ld_pos;
  logic                byte_ok, ld_ok;
  logic [VEC_W-1:0]    ld_bit;

  // Text update
  logic [VEC_W-1:0]        cur_word, active_nx, hits;
  logic [NUM_PATTERNS-1:0] found;

  assign ld_base = BITPOS_W'(in_slot) * BITPOS_W'(MAX_LEN);
  assign ld_pos  = ld_base + BITPOS_W'(in_idx);
  assign byte_ok = ({1'b0, in_byte} < (BYTE_W + 1)'(CHARSET));
  assign ld_ok   = (int'(in_slot) < NUM_PATTERNS) && (int'(in_idx) < MAX_LEN) &&
                   byte_ok && (ld_pos < BITPOS_W'(VEC_W));
  assign ld_bit  = VEC_W'(1) << ld_pos;

  // Masks of bytes not written since the last clear read as zero
  assign cur_word  = (op_inrange_q && valid_q[op_addr_q]) ? mem_rdata_q : '0;
  assign active_nx = ((active_q << 1) | start_q) & cur_word;
  assign hits      = active_nx & accept_q;
  assign mem_wdata = cur_word | op_bit_q;

  always_comb begin
    for (int s = 0; s < NUM_PATTERNS; s++) begin
      found[s] = |(hits & (FIELD_ONES << (s * MAX_LEN)));
    end
  end

  assign q_data_o = {pos_q, lens_q, found};

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    start_d      = start_q;
    accept_d     = accept_q;
    lens_d       = lens_q;
    active_d     = active_q;
    pos_d        = pos_q;
    op_addr_d    = op_addr_q;
    op_bit_d     = op_bit_q;
    op_inrange_d = op_inrange_q;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    q_push_o     = 1'b0;
    s_tready_o   = 1'b0;
    case (state_q)
      mpsa_pkg::FE_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          case (act)
            mpsa_pkg::ACT_CLEAR: begin
              valid_d  = '0;
              start_d  = '0;
              accept_d = '0;
              lens_d   = '0;
              active_d = '0;
              pos_d    = '0;
            end
            mpsa_pkg::ACT_LOAD: begin
              if (ld_ok) begin
                start_d = start_q | (VEC_W'(1) << ld_base);
                if (s_tlast_i) begin
                  accept_d = (accept_q & ~(FIELD_ONES << ld_base)) | ld_bit;
                  for (int s = 0; s < NUM_PATTERNS; s++) begin
                    if (int'(in_slot) == s) begin
                      lens_d[s*LEN_W +: LEN_W] = LEN_W'(in_idx) + LEN_W'(1);
                    end
                  end
                end
                op_addr_d    = in_byte[ADDR_W-1:0];
                op_bit_d     = ld_bit;
                op_inrange_d = 1'b1;
                mem_re       = 1'b1;
                state_d      = mpsa_pkg::FE_LOAD;
              end
            end
            mpsa_pkg::ACT_NEW_TEXT: begin
              active_d = '0;
              pos_d    = '0;
            end
            mpsa_pkg::ACT_TEXT: begin
              op_addr_d    = in_byte[ADDR_W-1:0];
              op_inrange_d = byte_ok;
              mem_re       = 1'b1;
              state_d      = mpsa_pkg::FE_TEXT;
            end
            default: begin
              state_d = mpsa_pkg::FE_IDLE;
            end
          endcase
        end
      end
      mpsa_pkg::FE_LOAD: begin
        // OR the pattern bit into the mask fetched last cycle
        mem_we             = 1'b1;
        valid_d[op_addr_q] = 1'b1;
        state_d            = mpsa_pkg::FE_IDLE;
      end
      mpsa_pkg::FE_TEXT: begin
        // Hold while a match record cannot be queued
        if (!q_full_i || (found == '0)) begin
          active_d = active_nx;
          pos_d    = pos_q + TPOS_W'(1);
          q_push_o = (found != '0);
          state_d  = mpsa_pkg::FE_IDLE;
        end
      end
      default: begin
        state_d = mpsa_pkg::FE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mpsa_pkg::FE_IDLE;
      valid_q  <= '0;
      start_q  <= '0;
      accept_q <= '0;
      lens_q   <= '0;
      active_q <= '0;
      pos_q    <= '0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      start_q  <= start_d;
      accept_q <= accept_d;
      lens_q   <= lens_d;
      active_q <= active_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_addr_q    <= op_addr_d;
    op_bit_q     <= op_bit_d;
    op_inrange_q <= op_inrange_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[op_addr_q] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[op_addr_d];
    end
  end

endmodule

// ----- rtl/mpsa_back.sv -----
// ----------------------------------------------------------------------------
// mpsa_back: match emitter
// Takes one match record from the queue and emits its slots lowest first,
// one result per cycle while the output is not stalled, capped per text byte.
// ----------------------------------------------------------------------------
module mpsa_back #(
  parameter int NUM_PATTERNS = mpsa_pkg::NUM_PATTERNS_DEF,
  parameter int ENTRY_W      = NUM_PATTERNS * (mpsa_pkg::LEN_W + 1) + mpsa_pkg::TPOS_W
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [ENTRY_W-1:0]               q_data_i,
  input  logic                             q_empty_i,
  output logic                             q_pop_o,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  output logic [mpsa_pkg::OUT_TDATA_W-1:0] m_tdata_o,
  output logic                             m_tlast_o
);

  localparam int LEN_W  = mpsa_pkg::LEN_W;
  localparam int TPOS_W = mpsa_pkg::TPOS_W;
  localparam int CNT_W  = mpsa_pkg::CNT_W;
  localparam int LENS_W = NUM_PATTERNS * LEN_W;

  logic [NUM_PATTERNS-1:0] pend_q, pend_d;
  logic [LENS_W-1:0]       lens_q, lens_d;
  logic [TPOS_W-1:0]       pos_q, pos_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;

  logic              out_valid_q, out_valid_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;
  logic [TPOS_W-1:0] out_start_q, out_start_d;
  logic              out_last_q, out_last_d;

  logic [NUM_PATTERNS-1:0] lowest, rest;
  logic [LEN_W-1:0]        len_sel;
  logic                    busy, out_free, emit, last;

  assign busy     = (pend_q != '0);
  assign out_free = !out_valid_q || m_tready_i;
  assign emit     = busy && out_free;
  assign q_pop_o  = !busy && !q_empty_i;

  assign lowest = pend_q & (~pend_q + NUM_PATTERNS'(1));
  assign rest   = pend_q & ~lowest;
  assign last   = (rest == '0) || (cnt_q == CNT_W'(mpsa_pkg::RESULT_CAP - 1));

  always_comb begin
    len_sel = '0;
    for (int s = 0; s < NUM_PATTERNS; s++) begin
      if (lowest[s]) begin
        len_sel = len_sel | lens_q[s*LEN_W +: LEN_W];
      end
    end
  end

  always_comb begin
    pend_d      = pend_q;
    lens_d      = lens_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_tready_i;
    out_len_d   = out_len_q;
    out_start_d = out_start_q;
    out_last_d  = out_last_q;
    if (q_pop_o) begin
      pend_d = q_data_i[NUM_PATTERNS-1:0];
      lens_d = q_data_i[NUM_PATTERNS +: LENS_W];
      pos_d  = q_data_i[ENTRY_W-1 -: TPOS_W];
      cnt_d  = '0;
    end else if (emit) begin
      // Drop the reported slot; drop the rest once the cap is reached
      pend_d      = last ? '0 : rest;
      cnt_d       = cnt_q + CNT_W'(1);
      out_valid_d = 1'b1;
      out_len_d   = len_sel;
      out_start_d = pos_q - TPOS_W'(len_sel) + TPOS_W'(1);
      out_last_d  = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lens_q      <= lens_d;
    pos_q       <= pos_d;
    out_len_q   <= out_len_d;
    out_start_q <= out_start_d;
    out_last_q  <= out_last_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = {(mpsa_pkg::OUT_TDATA_W - LEN_W - TPOS_W)'(0), out_start_q, out_len_q};

endmodule

// ----- rtl/multi_pattern_shift_and_matcher_core.sv -----
// ----------------------------------------------------------------------------
// multi_pattern_shift_and_matcher_core: multi-pattern shift-and text matcher
// Loads up to NUM_PATTERNS byte patterns into a per-character mask store and
// reports every pattern that ends at each text byte, lowest slot first.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  tdata (low bit up)                         tuser    tlast
//  s_axis   in   data_byte, pattern_slot, char_index, pad   action   last_char
//  m_axis   out  match_length, match_start, pad             -        last_match
//
//  Clear, start-new-text and a dropped pattern byte finish in the idle state;
//  a stored pattern byte or a text byte goes on to the load or text state for
//  the registered mask read. Each matching text byte's record passes the two-entry
//  queue, then each match result leaves the emitter at one a cycle unless m_axis stalls.
//  Reset clears all patterns, the vector and the text position at once.
//  A stalled m_axis holds the emitter; a matching text byte waits for room.
//
module multi_pattern_shift_and_matcher_core #(
  parameter int NUM_PATTERNS = mpsa_pkg::NUM_PATTERNS_DEF,
  parameter int MAX_LEN      = mpsa_pkg::MAX_LEN_DEF,
  parameter int CHARSET      = mpsa_pkg::CHARSET_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [7:0] data_byte, [10:8] pattern_slot, [13:11] char_index, [15:14] zero
  input  logic [mpsa_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] action
  input  logic [mpsa_pkg::ACT_W-1:0]       s_axis_tuser_i,
  input  logic                             s_axis_tlast_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [3:0] match_length, [35:4] match_start, [39:36] zero
  output logic [mpsa_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                             m_axis_tlast_o
);

  // One queue record: found slots, slot length snapshot, text position
  localparam int ENTRY_W = NUM_PATTERNS * (mpsa_pkg::LEN_W + 1) + mpsa_pkg::TPOS_W;

  logic               q_push, q_full, q_pop, q_empty;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  // Decode items, keep the pattern store and advance the shift-and vector
  mpsa_front #(
    .NUM_PATTERNS (NUM_PATTERNS),
    .MAX_LEN      (MAX_LEN),
    .CHARSET      (CHARSET),
    .ENTRY_W      (ENTRY_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .s_tlast_i  (s_axis_tlast_i),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata),
    .q_full_i   (q_full)
  );

  // Decouple the vector update from result delivery
  mpsa_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (mpsa_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  // Emit one result per matching slot, in slot order
  mpsa_back #(
    .NUM_PATTERNS (NUM_PATTERNS),
    .ENTRY_W      (ENTRY_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_data_i   (q_rdata),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule
